// ===== design/tbp_pkg.sv =====
package tbp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        block_kind;
        logic [15:0] block_length;
        logic [2:0]  status;
        logic [7:0]  flag_value;
        logic [7:0]  file_type;
        logic [15:0] payload_length;
        logic [15:0] param_one;
        logic [15:0] param_two;
        logic [7:0]  checksum_byte;
    } t_out_item;

    localparam int unsigned IDX_W = 5;

    // Body byte or end-of-file marker passed from framer to block checker.
    typedef struct packed {
        logic             eof;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic [15:0]      len;
    } t_token;

    localparam logic [7:0]  FLAG_HEADER = 8'h00;
    localparam logic [7:0]  FLAG_DATA   = 8'hFF;
    localparam logic [15:0] HEADER_LEN  = 16'd19;
    localparam logic [7:0]  MAX_TYPE    = 8'd3;
    localparam logic [15:0] MIN_DATA    = 16'd3;

    localparam logic [IDX_W-1:0] IDX_FLAG    = 5'd0;
    localparam logic [IDX_W-1:0] IDX_TYPE    = 5'd1;
    localparam logic [IDX_W-1:0] IDX_PLEN_LO = 5'd12;
    localparam logic [IDX_W-1:0] IDX_PLEN_HI = 5'd13;
    localparam logic [IDX_W-1:0] IDX_P1_LO   = 5'd14;
    localparam logic [IDX_W-1:0] IDX_P1_HI   = 5'd15;
    localparam logic [IDX_W-1:0] IDX_P2_LO   = 5'd16;
    localparam logic [IDX_W-1:0] IDX_P2_HI   = 5'd17;
    localparam logic [IDX_W-1:0] IDX_NONE    = 5'd31;
    localparam logic [15:0]      IDX_SAT_LIM = 16'd18;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FLAG  = 3'd1;
    localparam logic [2:0] ST_BAD_HLEN  = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;

endpackage

// ===== design/tape_block_parser.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_ready    o_out_item (t_out_item)
//
// One byte per cycle sustained; a result is registered as its block's last byte
// leaves the token queue and is offered in the cycle after.
// Input is held off only when the QUEUE_DEPTH-entry token queue is full.
// A stalled output register stops the queue; the framer keeps accepting until
// the queue fills. Synchronous active-low reset clears framing, queue and halt.
module tape_block_parser
    import tbp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic   q_full, q_valid, q_push, q_pop;
    t_token push_token, pop_token;

    tbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_token  (push_token)
    );

    tbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (push_token),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_token (pop_token)
    );

    tbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_token   (pop_token),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule

// ===== design/tbp_front.sv =====
module tbp_front
    import tbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_token   o_token
);

    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [15:0] idx_inc;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign idx_inc = r_idx + 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        o_push  = 1'b0;
        o_token.eof  = 1'b0;
        o_token.last = (idx_inc == r_len);
        o_token.idx  = (r_idx < IDX_SAT_LIM) ? r_idx[IDX_W-1:0] : IDX_NONE;
        o_token.data = i_item.data_byte;
        o_token.len  = r_len;
        if (accept) begin
            if (i_item.end_of_file) begin
                n_phase     = PH_LEN_LO;
                n_idx       = 16'd0;
                o_push      = 1'b1;
                o_token.eof = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_LEN_LO: begin
                        n_len   = {8'h00, i_item.data_byte};
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_len = {i_item.data_byte, r_len[7:0]};
                        n_idx = 16'd0;
                        // skip zero-length blocks
                        n_phase = (n_len == 16'd0) ? PH_LEN_LO : PH_BODY;
                    end
                    PH_BODY: begin
                        o_push = 1'b1;
                        if (idx_inc == r_len) begin
                            n_idx   = 16'd0;
                            n_phase = PH_LEN_LO;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    default: begin
                        n_phase = PH_LEN_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_LO;
            r_len   <= 16'd0;
            r_idx   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_idx < r_len))
        else $error("body index reached block length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_len != 16'd0))
        else $error("zero-length block entered body");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_item.end_of_file && r_phase == PH_LEN_LO) |-> !o_push)
        else $error("length byte forwarded as body");

endmodule

// ===== design/tbp_queue.sv =====
module tbp_queue
    import tbp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_token o_token
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_token            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== design/tbp_back.sv =====
module tbp_back
    import tbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_token    i_token,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic        r_halted, n_halted;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_plen, n_plen;
    logic [15:0] r_p1, n_p1;
    logic [15:0] r_p2, n_p2;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic        produce;
    logic        hdr_fields;
    logic [2:0]  status;
    logic        kind;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_halted = r_halted;
        n_xor    = r_xor ^ i_token.data;
        n_first  = r_first;
        n_type   = r_type;
        n_plen   = r_plen;
        n_p1     = r_p1;
        n_p2     = r_p2;
        if (i_token.idx == IDX_FLAG) begin
            n_xor   = i_token.data;
            n_first = i_token.data;
            n_type  = 8'h00;
            n_plen  = 16'h0000;
            n_p1    = 16'h0000;
            n_p2    = 16'h0000;
        end
        unique case (i_token.idx)
            IDX_TYPE:    n_type       = i_token.data;
            IDX_PLEN_LO: n_plen[7:0]  = i_token.data;
            IDX_PLEN_HI: n_plen[15:8] = i_token.data;
            IDX_P1_LO:   n_p1[7:0]    = i_token.data;
            IDX_P1_HI:   n_p1[15:8]   = i_token.data;
            IDX_P2_LO:   n_p2[7:0]    = i_token.data;
            IDX_P2_HI:   n_p2[15:8]   = i_token.data;
            default: ;
        endcase

        // check order: flag, then length, then type, then checksum
        hdr_fields = 1'b0;
        kind       = 1'b0;
        status     = ST_OK;
        if (n_first == FLAG_HEADER) begin
            if (i_token.len != HEADER_LEN) begin
                status = ST_BAD_HLEN;
            end else begin
                hdr_fields = 1'b1;
                if (n_type > MAX_TYPE) begin
                    status = ST_BAD_TYPE;
                end else if (n_xor != 8'h00) begin
                    status = ST_CHECKSUM;
                end
            end
        end else if (n_first == FLAG_DATA) begin
            kind = 1'b1;
            if (i_token.len < MIN_DATA) begin
                status = ST_SHORT;
            end else if (n_xor != 8'h00) begin
                status = ST_CHECKSUM;
            end
        end else begin
            status = ST_BAD_FLAG;
        end

        produce = o_pop && !i_token.eof && !r_halted && i_token.last;

        n_out.block_kind     = kind;
        n_out.block_length   = i_token.len;
        n_out.status         = status;
        n_out.flag_value     = n_first;
        n_out.file_type      = hdr_fields ? n_type : 8'h00;
        n_out.payload_length = hdr_fields ? n_plen : 16'h0000;
        n_out.param_one      = hdr_fields ? n_p1 : 16'h0000;
        n_out.param_two      = hdr_fields ? n_p2 : 16'h0000;
        n_out.checksum_byte  = i_token.data;

        if (o_pop && i_token.eof) begin
            n_halted = 1'b0;
        end else if (produce && status != ST_OK) begin
            n_halted = 1'b1;
        end

        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_token.eof && !r_halted) begin
            r_xor   <= n_xor;
            r_first <= n_first;
            r_type  <= n_type;
            r_plen  <= n_plen;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
        end
        if (produce) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !produce)
        else $error("result produced after an error");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_halted)
        else $error("failed block did not halt parsing");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.block_kind) |->
            (r_out.file_type == 8'h00 && r_out.payload_length == 16'h0000))
        else $error("header fields set on data block");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tbp_pkg::*;

    typedef enum logic [1:0] {
        SEEK_LEN_LO,
        SEEK_LEN_HI,
        IN_BODY,
        HALTED
    } t_tape_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    tape_block_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item    pending_bytes[$];
    t_out_item   expected_blocks[$];
    t_out_item   predicted_block;
    int unsigned n_generated = 0;
    int unsigned n_accepted = 0;
    int unsigned n_fail = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Parser state mirrored by the predictor
    t_tape_phase tp_phase = SEEK_LEN_LO;
    logic [15:0] blk_len = '0;
    logic [15:0] body_idx = '0;
    logic [7:0]  run_xor = '0;
    logic [7:0]  flag_b = '0;
    logic [7:0]  type_b = '0;
    logic [15:0] plen_f = '0;
    logic [15:0] parm1_f = '0;
    logic [15:0] parm2_f = '0;
    logic [7:0]  last_b = '0;

    function automatic void clear_capture();
        body_idx = '0;
        run_xor  = '0;
        flag_b   = '0;
        type_b   = '0;
        plen_f   = '0;
        parm1_f  = '0;
        parm2_f  = '0;
        last_b   = '0;
    endfunction

    function automatic bit tape_predict(input t_in_item it, output t_out_item res);
        bit         hdr;
        logic       kind;
        logic [2:0] st;
        logic [7:0] b;
        hdr  = 1'b0;
        kind = 1'b0;
        st   = ST_OK;
        b    = it.data_byte;
        res  = '0;
        if (it.end_of_file) begin
            clear_capture();
            blk_len  = '0;
            tp_phase = SEEK_LEN_LO;
            return 1'b0;
        end
        case (tp_phase)
            SEEK_LEN_LO: begin
                blk_len  = {8'h00, b};
                tp_phase = SEEK_LEN_HI;
                return 1'b0;
            end
            SEEK_LEN_HI: begin
                blk_len[15:8] = b;
                if (blk_len == 16'd0) begin
                    tp_phase = SEEK_LEN_LO;
                end else begin
                    clear_capture();
                    tp_phase = IN_BODY;
                end
                return 1'b0;
            end
            IN_BODY: ;
            default: return 1'b0;
        endcase

        run_xor = run_xor ^ b;
        last_b  = b;
        case (body_idx)
            16'd0:  flag_b = b;
            16'd1:  type_b = b;
            16'd12: plen_f[7:0] = b;
            16'd13: plen_f[15:8] = b;
            16'd14: parm1_f[7:0] = b;
            16'd15: parm1_f[15:8] = b;
            16'd16: parm2_f[7:0] = b;
            16'd17: parm2_f[15:8] = b;
            default: ;
        endcase
        body_idx = body_idx + 16'd1;
        if (body_idx != blk_len) return 1'b0;

        // Flag decides the kind; first failing check wins
        if (flag_b == FLAG_HEADER) begin
            if (blk_len != HEADER_LEN) begin
                st = ST_BAD_HLEN;
            end else begin
                hdr = 1'b1;
                if (type_b > MAX_TYPE) st = ST_BAD_TYPE;
                else if (run_xor != 8'h00) st = ST_CHECKSUM;
            end
        end else if (flag_b == FLAG_DATA) begin
            kind = 1'b1;
            if (blk_len < MIN_DATA) st = ST_SHORT;
            else if (run_xor != 8'h00) st = ST_CHECKSUM;
        end else begin
            st = ST_BAD_FLAG;
        end

        res.block_kind     = kind;
        res.block_length   = blk_len;
        res.status         = st;
        res.flag_value     = flag_b;
        res.file_type      = hdr ? type_b : 8'h00;
        res.payload_length = hdr ? plen_f : 16'h0000;
        res.param_one      = hdr ? parm1_f : 16'h0000;
        res.param_two      = hdr ? parm2_f : 16'h0000;
        res.checksum_byte  = last_b;

        tp_phase = (st != ST_OK) ? HALTED : SEEK_LEN_LO;
        body_idx = '0;
        return 1'b1;
    endfunction

    // Stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        t_in_item it;
        it.data_byte   = b;
        it.end_of_file = 1'b0;
        pending_bytes.push_back(it);
        n_generated++;
    endtask

    task automatic push_eof();
        t_in_item it;
        it.data_byte   = 8'($urandom);
        it.end_of_file = 1'b1;
        pending_bytes.push_back(it);
        n_generated++;
    endtask

    task automatic push_len(input logic [15:0] len);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
    endtask

    // Frame a block; from two bytes on, the last byte closes the XOR unless bad_sum corrupts it
    task automatic send_block(input int len, input logic [7:0] flag, input logic [7:0] ftype,
                              input bit bad_sum, input int fill);
        logic [7:0] body[$];
        logic [7:0] v;
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < len; i++) begin
            v = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 0) v = flag;
            if (i == 1) v = ftype;
            body.push_back(v);
        end
        if (len >= 2) begin
            for (int i = 0; i < len - 1; i++) x = x ^ body[i];
            body[len-1] = bad_sum ? (x ^ 8'($urandom_range(1, 255))) : x;
        end
        push_len(16'(len));
        foreach (body[i]) push_byte(body[i]);
    endtask

    function automatic int pick_fill();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return -1;
    endfunction

    task automatic random_tape();
        int         r;
        int         len;
        int         nblk;
        bit         ended;
        logic [7:0] f;
        ended = 1'b0;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 30)) push_byte(8'($urandom));
            push_eof();
            return;
        end
        nblk = $urandom_range(1, 6);
        for (int k = 0; k < nblk && !ended; k++) begin
            r = $urandom_range(99);
            if (r < 38) begin
                send_block(19, FLAG_HEADER, 8'($urandom_range(0, 3)), 1'b0, pick_fill());
            end else if (r < 76) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(256, 300)
                                                : $urandom_range(3, 40);
                send_block(len, FLAG_DATA, 8'($urandom), 1'b0, pick_fill());
            end else if (r < 82) begin
                push_len(16'd0);
            end else begin
                case ($urandom_range(4))
                    0: begin
                        f = 8'($urandom);
                        if (f == FLAG_HEADER || f == FLAG_DATA) f = 8'h42;
                        send_block($urandom_range(1, 25), f, 8'($urandom), 1'b0, -1);
                    end
                    1: begin
                        len = $urandom_range(1, 30);
                        if (len == 19) len = 20;
                        send_block(len, FLAG_HEADER, 8'($urandom_range(0, 3)), 1'b0, -1);
                    end
                    2: send_block(19, FLAG_HEADER, 8'($urandom_range(4, 255)),
                                  1'($urandom_range(1)), -1);
                    3: send_block($urandom_range(1, 2), FLAG_DATA, 8'($urandom), 1'b0, -1);
                    default: begin
                        if ($urandom_range(1))
                            send_block(19, FLAG_HEADER, 8'($urandom_range(0, 3)), 1'b1, -1);
                        else
                            send_block($urandom_range(3, 40), FLAG_DATA, 8'($urandom), 1'b1, -1);
                    end
                endcase
                // Trailing bytes must be ignored until end of file
                repeat ($urandom_range(0, 8)) push_byte(8'($urandom));
                ended = 1'b1;
            end
        end
        if (!ended && $urandom_range(4) == 0) begin
            len = $urandom_range(2, 60);
            if ($urandom_range(5) == 0) begin
                push_byte(8'(len));
            end else begin
                push_len(16'(len));
                repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom));
            end
        end
        push_eof();
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    task automatic check_block(input t_out_item got);
        t_out_item want;
        want = expected_blocks.pop_front();
        check_field("block_kind", want.block_kind, got.block_kind);
        check_field("block_length", want.block_length, got.block_length);
        check_field("status", want.status, got.status);
        check_field("flag_value", want.flag_value, got.flag_value);
        check_field("file_type", want.file_type, got.file_type);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("param_one", want.param_one, got.param_one);
        check_field("param_two", want.param_two, got.param_two);
        check_field("checksum_byte", want.checksum_byte, got.checksum_byte);
    endtask

    // Driver: predict on each accepted transaction, then load the next byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                n_accepted++;
                if (tape_predict(i_in_item, predicted_block))
                    expected_blocks.push_back(predicted_block);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected result: block_length 0x%0h status %0d",
                       o_out_item.block_length, o_out_item.status);
                n_fail++;
            end else begin
                check_block(o_out_item);
            end
        end
    end

    initial begin
        int target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases with no idling
        push_eof();
        push_len(16'd0);
        push_len(16'd3);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_block(19, FLAG_HEADER, 8'd3, 1'b0, 255);
        send_block(19, FLAG_HEADER, 8'd0, 1'b0, 0);
        send_block(19, FLAG_HEADER, 8'd4, 1'b0, -1);
        push_byte(8'h55);
        push_byte(8'hAA);
        push_eof();
        send_block(18, FLAG_HEADER, 8'd1, 1'b0, -1);
        push_eof();
        send_block(2, FLAG_DATA, 8'h00, 1'b0, -1);
        push_eof();
        send_block(1, 8'h5A, 8'h00, 1'b0, -1);
        push_eof();
        send_block(4, FLAG_DATA, 8'h12, 1'b1, -1);
        push_eof();
        push_len(16'hFFFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        push_eof();
        push_byte(8'h07);
        push_eof();
        while (n_accepted != n_generated) @(posedge i_clk);

        // Each chunk overshoots its target by part of a tape
        for (int chunk = 0; chunk < 8; chunk++) begin
            case (chunk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            target = n_generated + 45;
            while (n_generated < target) random_tape();
            while (n_accepted != n_generated) @(posedge i_clk);
        end

        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
